// ===== design/arh_pkg.sv =====
// ----------------------------------------------------------------------------
// arh_pkg
// Shared constants and types for the auto-ranging histogram.
// ----------------------------------------------------------------------------
package arh_pkg;

  // Width of the bin-count configuration register and of the bin_cnt_t type.
  localparam int unsigned CFG_W     = 7;
  // Width of the bin index carried on each result beat.
  localparam int unsigned BIN_IDX_W = 6;
  // Reset value of the bin-count register.
  localparam logic [CFG_W-1:0] NUM_BINS_RESET = 7'd10;

  typedef logic [CFG_W-1:0] bin_cnt_t;

endpackage

// ===== design/arh_ram.sv =====
// ----------------------------------------------------------------------------
// arh_ram
// Generic simple dual-port RAM: one write port, one read port, and registered
// read data.
// ----------------------------------------------------------------------------
module arh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/arh_div.sv =====
// ----------------------------------------------------------------------------
// arh_div
// Restoring divider: an unsigned range divided by a bin count, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module arh_div
  import arh_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     dividend,
  input  bin_cnt_t         divisor,
  output logic             done,
  output logic [W-1:0]     quotient
);

  localparam int unsigned SW = $clog2(W + 1);

  logic [W-1:0]     q_r, q_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  bin_cnt_t         dvs_r, dvs_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CFG_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    trial    = {rem_r, q_r[W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // The remainder always stays below the divisor, so it fits CFG_W bits.
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CFG_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CFG_W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== design/auto_range_histogram.sv =====
// ----------------------------------------------------------------------------
// auto_range_histogram
// Auto-ranging equal-width histogram over a stored set of signed samples.
// ----------------------------------------------------------------------------
// Samples are taken one beat per cycle into a sample memory while a running
// minimum and maximum are kept; beats beyond MAX_SAMPLES are dropped and
// reported through the overflow flag. The beat marked last closes the set.
// The block then stops accepting samples: it clears the bin-count memory
// while a one-bit-per-cycle divider forms the bin width, then re-reads every
// stored sample and bins it with a binary search over the bin edges, one edge
// multiply and compare per cycle. Each stored sample passes through the
// sample memory read, the search and the read-modify-write of the count
// memory before the next one is read. Finally one result beat per bin is
// sent; each bin's count is read and shown, and held until the receiver
// takes it. A num_bins value of zero discards the set without results;
// values above MAX_BINS act as MAX_BINS. Configuration writes are always
// taken and belong between sets.
// ----------------------------------------------------------------------------
module auto_range_histogram
  import arh_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write channel: number of bins.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_W-1:0]                     cfg_num_bins,
  // Sample channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 in_last_sample,
  // Result channel, one beat per bin.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [BIN_IDX_W-1:0]                 out_bin_index,
  output logic signed [SAMPLE_BITS-1:0]        out_bin_low,
  output logic signed [SAMPLE_BITS-1:0]        out_bin_high,
  output logic signed [SAMPLE_BITS-1:0]        out_bin_center,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]     out_bin_count,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]     out_max_count,
  output logic                                 out_overflow,
  output logic                                 out_last_bin
);

  localparam int unsigned W   = SAMPLE_BITS;
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SA  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned BA  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned PW  = W + CFG_W;
  localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_LOAD, S_PREP, S_BRD, S_SRCH, S_CUPD, S_ORD, S_OSHOW, S_OWAIT
  } state_t;

  state_t          state_r, state_nxt;
  bin_cnt_t        num_bins_r, num_bins_nxt;
  bin_cnt_t        nb_r, nb_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [W-1:0]    min_r, min_nxt;
  logic [W-1:0]    max_r, max_nxt;
  logic            drop_r, drop_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  bin_cnt_t        slo_r, slo_nxt;
  bin_cnt_t        shi_r, shi_nxt;
  bin_cnt_t        clr_r, clr_nxt;
  bin_cnt_t        bin_r, bin_nxt;
  logic [CW-1:0]   maxc_r, maxc_nxt;
  logic [W-1:0]    edge_r, edge_nxt;

  logic [BIN_IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic [W-1:0]    o_low_r, o_low_nxt;
  logic [W-1:0]    o_high_r, o_high_nxt;
  logic [W-1:0]    o_ctr_r, o_ctr_nxt;
  logic [CW-1:0]   o_cnt_r, o_cnt_nxt;
  logic [CW-1:0]   o_maxc_r, o_maxc_nxt;
  logic            o_ovf_r, o_ovf_nxt;
  logic            o_last_r, o_last_nxt;
  logic            o_valid_r, o_valid_nxt;

  // Sample memory ports.
  logic            st_we, st_re;
  logic [SA-1:0]   st_waddr, st_raddr;
  logic [W-1:0]    st_wdata, st_rdata;
  // Count memory ports.
  logic            ct_we, ct_re;
  logic [BA-1:0]   ct_waddr, ct_raddr;
  logic [CW-1:0]   ct_wdata, ct_rdata;

  logic            div_start;
  logic            div_done;
  logic [W-1:0]    div_dividend;
  logic [W-1:0]    width;

  // Datapath helpers.
  logic [W-1:0]    samp_b;
  logic            first;
  logic            room;
  bin_cnt_t        nb_clamp;
  bin_cnt_t        mid;
  bin_cnt_t        mid1;
  logic [PW-1:0]   prod;
  logic [PW:0]     edge_val;
  logic [W-1:0]    hi_b;
  logic [CW-1:0]   inc;

  arh_ram #(.WIDTH(W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  arh_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_counts (
    .clk   (clk),
    .we    (ct_we),
    .waddr (ct_waddr),
    .wdata (ct_wdata),
    .re    (ct_re),
    .raddr (ct_raddr),
    .rdata (ct_rdata)
  );

  arh_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (nb_nxt),
    .done     (div_done),
    .quotient (width)
  );

  // Samples are kept in offset-binary form so that every compare and
  // difference below is unsigned.
  assign samp_b   = W'(in_sample) ^ SIGN_BIT;
  assign first    = (count_r == '0);
  assign room     = (count_r < CW'(MAX_SAMPLES));
  assign nb_clamp = (num_bins_r > CFG_W'(MAX_BINS)) ? CFG_W'(MAX_BINS) : num_bins_r;

  // Binary search step: the upper edge of bin mid is min + width*(mid+1).
  assign mid      = CFG_W'(({1'b0, slo_r} + {1'b0, shi_r}) >> 1);
  assign mid1     = mid + 1'b1;
  assign prod     = PW'(width) * PW'(mid1);
  assign edge_val = (PW+1)'(min_r) + (PW+1)'(prod);
  assign hi_b     = edge_r + width;
  assign inc      = ct_rdata + 1'b1;

  assign in_ready  = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    num_bins_nxt = num_bins_r;
    nb_nxt       = nb_r;
    count_nxt    = count_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    drop_nxt     = drop_r;
    idx_nxt      = idx_r;
    slo_nxt      = slo_r;
    shi_nxt      = shi_r;
    clr_nxt      = clr_r;
    bin_nxt      = bin_r;
    maxc_nxt     = maxc_r;
    edge_nxt     = edge_r;
    o_idx_nxt    = o_idx_r;
    o_low_nxt    = o_low_r;
    o_high_nxt   = o_high_r;
    o_ctr_nxt    = o_ctr_r;
    o_cnt_nxt    = o_cnt_r;
    o_maxc_nxt   = o_maxc_r;
    o_ovf_nxt    = o_ovf_r;
    o_last_nxt   = o_last_r;
    o_valid_nxt  = o_valid_r;

    st_we        = 1'b0;
    st_waddr     = count_r[SA-1:0];
    st_wdata     = samp_b;
    st_re        = 1'b0;
    st_raddr     = idx_r[SA-1:0];
    ct_we        = 1'b0;
    ct_waddr     = clr_r[BA-1:0];
    ct_wdata     = '0;
    ct_re        = 1'b0;
    ct_raddr     = slo_r[BA-1:0];
    div_start    = 1'b0;
    div_dividend = max_r - min_r;

    if (cfg_valid) begin
      num_bins_nxt = cfg_num_bins;
    end

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (room) begin
            st_we     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (first) begin
              min_nxt  = samp_b;
              max_nxt  = samp_b;
              drop_nxt = 1'b0;
            end else begin
              if (samp_b < min_r) min_nxt = samp_b;
              if (samp_b > max_r) max_nxt = samp_b;
            end
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_sample) begin
            if (nb_clamp == '0) begin
              count_nxt = '0;
              drop_nxt  = 1'b0;
            end else begin
              // Start the width division on the final range right away.
              nb_nxt        = nb_clamp;
              div_start     = 1'b1;
              div_dividend  = max_nxt - min_nxt;
              clr_nxt       = '0;
              state_nxt     = S_PREP;
            end
          end
        end
      end

      S_PREP: begin
        if (clr_r < CFG_W'(MAX_BINS)) begin
          ct_we   = 1'b1;
          clr_nxt = clr_r + 1'b1;
        end else if (div_done) begin
          idx_nxt   = '0;
          maxc_nxt  = '0;
          state_nxt = S_BRD;
        end
      end

      S_BRD: begin
        st_re     = 1'b1;
        slo_nxt   = '0;
        shi_nxt   = nb_r - 1'b1;
        state_nxt = S_SRCH;
      end

      S_SRCH: begin
        if (slo_r == shi_r) begin
          ct_re     = 1'b1;
          state_nxt = S_CUPD;
        end else if ((PW+1)'(st_rdata) <= edge_val) begin
          shi_nxt = mid;
        end else begin
          slo_nxt = mid1;
        end
      end

      S_CUPD: begin
        // Only one sample is in flight, so the read-modify-write of a count
        // entry never overlaps another access to it.
        ct_we    = 1'b1;
        ct_waddr = slo_r[BA-1:0];
        ct_wdata = inc;
        if (inc > maxc_r) maxc_nxt = inc;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r + 1'b1 == count_r) begin
          bin_nxt   = '0;
          edge_nxt  = min_r;
          state_nxt = S_ORD;
        end else begin
          state_nxt = S_BRD;
        end
      end

      S_ORD: begin
        ct_re     = 1'b1;
        ct_raddr  = bin_r[BA-1:0];
        state_nxt = S_OSHOW;
      end

      S_OSHOW: begin
        o_idx_nxt   = bin_r[BIN_IDX_W-1:0];
        o_low_nxt   = edge_r ^ SIGN_BIT;
        o_high_nxt  = hi_b ^ SIGN_BIT;
        o_ctr_nxt   = (edge_r + (width >> 1)) ^ SIGN_BIT;
        o_cnt_nxt   = ct_rdata;
        o_maxc_nxt  = maxc_r;
        o_ovf_nxt   = drop_r;
        o_last_nxt  = (bin_r + 1'b1 == nb_r);
        o_valid_nxt = 1'b1;
        state_nxt   = S_OWAIT;
      end

      S_OWAIT: begin
        if (out_ready) begin
          o_valid_nxt = 1'b0;
          edge_nxt    = hi_b;
          bin_nxt     = bin_r + 1'b1;
          if (o_last_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      num_bins_r <= NUM_BINS_RESET;
      count_r    <= '0;
      min_r      <= '0;
      max_r      <= '0;
      drop_r     <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      num_bins_r <= num_bins_nxt;
      count_r    <= count_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      drop_r     <= drop_nxt;
      o_valid_r  <= o_valid_nxt;
    end
    nb_r     <= nb_nxt;
    idx_r    <= idx_nxt;
    slo_r    <= slo_nxt;
    shi_r    <= shi_nxt;
    clr_r    <= clr_nxt;
    bin_r    <= bin_nxt;
    maxc_r   <= maxc_nxt;
    edge_r   <= edge_nxt;
    o_idx_r  <= o_idx_nxt;
    o_low_r  <= o_low_nxt;
    o_high_r <= o_high_nxt;
    o_ctr_r  <= o_ctr_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_maxc_r <= o_maxc_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid      = o_valid_r;
  assign out_bin_index  = o_idx_r;
  assign out_bin_low    = o_low_r;
  assign out_bin_high   = o_high_r;
  assign out_bin_center = o_ctr_r;
  assign out_bin_count  = o_cnt_r;
  assign out_max_count  = o_maxc_r;
  assign out_overflow   = o_ovf_r;
  assign out_last_bin   = o_last_r;

endmodule

// ===== verif/arh_checker.sv =====
// ----------------------------------------------------------------------------
// arh_checker
// Scoreboard for the auto-ranging histogram.
// ----------------------------------------------------------------------------
// Follows every configuration, sample and result beat. It keeps its own copy
// of the sample store and the range, works out the per-bin results when a
// set closes, and checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module arh_checker
  import arh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_num_bins,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [31:0]   in_sample,
  input  logic                 in_last_sample,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [BIN_IDX_W-1:0] out_bin_index,
  input  logic signed [31:0]   out_bin_low,
  input  logic signed [31:0]   out_bin_high,
  input  logic signed [31:0]   out_bin_center,
  input  logic [12:0]          out_bin_count,
  input  logic [12:0]          out_max_count,
  input  logic                 out_overflow,
  input  logic                 out_last_bin,
  output int                   fail_count,
  output int                   bins_pending
);

  localparam int STORE_DEPTH = 4096;
  localparam int BIN_LIMIT   = 64;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] index;
    logic [31:0]          low;
    logic [31:0]          high;
    logic [31:0]          center;
    logic [12:0]          count;
    logic [12:0]          peak;
    logic                 overflow;
    logic                 last;
  } bin_result_t;

  bin_result_t expected_bins[$];

  // Samples are held in offset-binary form so that ordering is unsigned.
  logic [31:0] biased_store[STORE_DEPTH];
  int          stored;
  logic [31:0] range_min;
  logic [31:0] range_max;
  logic        dropped;
  bin_cnt_t    bins_cfg;

  assign bins_pending = expected_bins.size();

  task automatic close_set();
    int          nb;
    int          j;
    int          peak;
    int          counts[BIN_LIMIT];
    logic [63:0] width;
    logic [63:0] lo;
    logic [63:0] hi;
    bin_result_t r;
    nb = (bins_cfg > BIN_LIMIT) ? BIN_LIMIT : int'(bins_cfg);
    if (nb != 0) begin
      width = 64'(range_max - range_min) / nb;
      for (j = 0; j < BIN_LIMIT; j++) counts[j] = 0;
      for (int i = 0; i < stored; i++) begin
        for (j = 0; j + 1 < nb; j++)
          if (64'(biased_store[i]) <= 64'(range_min) + width * (j + 1)) break;
        counts[j]++;
      end
      peak = 0;
      for (j = 0; j < nb; j++) if (counts[j] > peak) peak = counts[j];
      lo = 64'(range_min);
      for (j = 0; j < nb; j++) begin
        hi = 64'(range_min) + width * (j + 1);
        r.index    = BIN_IDX_W'(j);
        r.low      = lo[31:0] ^ 32'h8000_0000;
        r.high     = hi[31:0] ^ 32'h8000_0000;
        r.center   = 32'(lo + (hi - lo) / 2) ^ 32'h8000_0000;
        r.count    = 13'(counts[j]);
        r.peak     = 13'(peak);
        r.overflow = dropped;
        r.last     = (j + 1 == nb);
        expected_bins.push_back(r);
        lo = hi;
      end
    end
    stored  = 0;
    dropped = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic [31:0] b;
    bin_result_t want;
    if (!rst_n) begin
      stored     = 0;
      range_min  = '0;
      range_max  = '0;
      dropped    = 1'b0;
      bins_cfg   = NUM_BINS_RESET;
      fail_count = 0;
      expected_bins.delete();
    end else begin
      if (cfg_valid && cfg_ready) bins_cfg = cfg_num_bins;
      if (in_valid && in_ready) begin
        b = in_sample ^ 32'h8000_0000;
        if (stored == 0) begin
          range_min = b;
          range_max = b;
          dropped   = 1'b0;
        end
        if (stored < STORE_DEPTH) begin
          biased_store[stored] = b;
          stored++;
          if (b < range_min) range_min = b;
          if (b > range_max) range_max = b;
        end else begin
          dropped = 1'b1;
        end
        if (in_last_sample) close_set();
      end
      if (out_valid && out_ready) begin
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual bin %0d",
                   $time, out_bin_index);
          fail_count++;
        end else begin
          want = expected_bins.pop_front();
          check_field("bin_index", 32'(want.index), 32'(out_bin_index));
          check_field("bin_low", want.low, out_bin_low);
          check_field("bin_high", want.high, out_bin_high);
          check_field("bin_center", want.center, out_bin_center);
          check_field("bin_count", 32'(want.count), 32'(out_bin_count));
          check_field("max_count", 32'(want.peak), 32'(out_max_count));
          check_field("overflow", 32'(want.overflow), 32'(out_overflow));
          check_field("last_bin", 32'(want.last), 32'(out_last_bin));
        end
      end
    end
  end

endmodule

// ===== verif/auto_range_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// auto_range_histogram_tb
// Stimulus and verdict for the auto-ranging histogram.
// ----------------------------------------------------------------------------
// Sends directed data sets (range extremes, single samples, zero width, zero
// and oversized bin counts) and then random sets under random bin counts.
// The sender works in bursts and the receiver stalls on its own pattern.
// All checking happens in arh_checker.
// ----------------------------------------------------------------------------
module auto_range_histogram_tb;
  import arh_pkg::*;

  // Cycles to let the block finish a set that produces no results before
  // the bin count is changed. Sets here stay well under a hundred samples.
  localparam int SETTLE_CYCLES = 2500;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BEATS  = 320;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_num_bins;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [31:0]   in_sample;
  logic                 in_last_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [BIN_IDX_W-1:0] out_bin_index;
  logic signed [31:0]   out_bin_low;
  logic signed [31:0]   out_bin_high;
  logic signed [31:0]   out_bin_center;
  logic [12:0]          out_bin_count;
  logic [12:0]          out_max_count;
  logic                 out_overflow;
  logic                 out_last_bin;
  int                   fail_count;
  int                   bins_pending;
  int                   cycles;
  int                   burst_left;
  int                   random_sent;

  auto_range_histogram uut (.*);

  arh_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is ended here if the block stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches between always ready, random stalls and a slow
  // fixed pattern, holding each mode for a random stretch.
  int stall_mode;
  int stall_left;
  int stall_phase;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= (stall_phase % 5 == 0);
    endcase
  end

  // One sample beat. A gap is only inserted when its length is nonzero,
  // so valid is never dropped and raised in the same step.
  task automatic send_beat(logic [31:0] s, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (last) begin
      // Closing beat: release valid so the stale beat is not taken again.
      in_valid   <= 1'b0;
      burst_left = 0;
      @(posedge clk);
    end
  endtask

  // Bin count changes only once the block is drained and settled.
  task automatic write_bins(bin_cnt_t value);
    while (bins_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_num_bins <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample(int flavor, logic [31:0] base);
    case (flavor)
      0: return $urandom;
      1: return base + $urandom_range(0, 255);
      2: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return base;
    endcase
  endfunction

  task automatic send_random_set(int len);
    int          flavor;
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      // Mostly mixed content so that sets spread over many bins.
      flavor = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 1) : $urandom_range(0, 3);
      send_beat(pick_sample(flavor, base), i == len - 1);
    end
  endtask

  initial begin
    bin_cnt_t nb;
    cycles         = 0;
    burst_left     = 0;
    random_sent    = 0;
    stall_mode     = 0;
    stall_left     = 0;
    stall_phase    = 0;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_num_bins   = '0;
    in_valid       = 1'b0;
    in_sample      = '0;
    in_last_sample = 1'b0;
    out_ready      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default bin count: both range extremes in one set, then one sample.
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h0000_0001, 1'b0);
    send_beat(32'hffff_ffff, 1'b1);
    send_beat(32'h0001_8000, 1'b1);

    // A single bin takes everything.
    write_bins(7'd1);
    send_beat(32'h1234_5678, 1'b0);
    send_beat(32'hedcb_a987, 1'b0);
    send_beat(32'h0000_0000, 1'b1);

    // Most bins with a range narrower than the bin count: zero bin width.
    write_bins(7'd64);
    send_beat(32'h0000_0010, 1'b0);
    send_beat(32'h0000_0010, 1'b0);
    send_beat(32'h0000_0020, 1'b0);
    send_beat(32'h0000_0015, 1'b1);
    send_random_set(8);

    // Zero bins discards the set; the next set starts fresh.
    write_bins(7'd0);
    send_random_set(3);

    // Counts above the bin memory act as the largest count.
    write_bins(7'd127);
    send_random_set(6);
    write_bins(7'd100);
    send_random_set(4);

    // Random part.
    while (random_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0: nb = 7'd1;
        1: nb = 7'd64;
        2: nb = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
        default: nb = 7'($urandom_range(1, 64));
      endcase
      write_bins(nb);
      repeat ($urandom_range(1, 4)) begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        send_random_set(len);
        random_sent += len;
      end
    end

    while (bins_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
